FILE: rtl/core/ckr_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ckr_pkg
// Shared types, widths, constants and rounding helpers of the cosine-kernel
// stereo resampler.
// ----------------------------------------------------------------------------
package ckr_pkg;

    localparam int FRAC_BITS       = 24;
    localparam int MAX_OUT_DEFAULT = 16;
    localparam int SAMPLE_W        = 16;
    localparam int PHASE_W         = 40;
    localparam int STEP_W          = 29;
    localparam int SCALE_W         = 27;
    localparam int CFG_IDX_W       = 2;
    localparam int CFG_DATA_W      = 29;
    localparam int ACC_W           = 64;
    localparam int XW              = 44;
    localparam int MW              = 28;
    localparam int PW              = 2 * MW;
    localparam int LO_W            = FRAC_BITS + 2;
    localparam int HI_W            = XW - LO_W;
    localparam int WIDE_W          = 72;

    localparam longint Q_ONE      = 64'sd1 << FRAC_BITS;
    localparam longint Q_HALF     = 64'sd1 << (FRAC_BITS - 1);
    localparam longint Q_TWO      = 64'sd2 << FRAC_BITS;
    localparam longint Q_THREE    = 64'sd3 << FRAC_BITS;
    localparam longint PROD_LIMIT = 64'sd1 << (2 * FRAC_BITS + 1);

    localparam logic [PW-1:0]    HALF_PW  = PW'(Q_HALF);
    localparam logic [ACC_W-1:0] HALF_ACC = ACC_W'(Q_HALF);

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_MODE  = 2'd0,
        REG_STEP  = 2'd1,
        REG_SCALE = 2'd2
    } ckr_reg_idx_t;

    typedef struct packed {
        logic               mode_wr;
        logic               mode_val;
        logic               mode;
        logic [STEP_W-1:0]  step;
        logic [SCALE_W-1:0] scale;
    } ckr_cfg_t;

    typedef struct packed {
        logic                       last;
        logic signed [SAMPLE_W-1:0] right;
        logic signed [SAMPLE_W-1:0] left;
    } ckr_frame_t;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_ARG,
        ST_MHI,
        ST_MLO,
        ST_USAT,
        ST_U2,
        ST_U2W,
        ST_T1,
        ST_T1W,
        ST_UT,
        ST_IW,
        ST_TL,
        ST_TR,
        ST_TRW,
        ST_DS_PH,
        ST_DS_CHK,
        ST_DS_EMIT,
        ST_UP_CHECK,
        ST_UP_ADV,
        ST_UP_EMIT
    } ckr_state_t;

    // product scaled down, rounded half away from zero
    function automatic logic signed [PW-1:0] round_prod(input logic signed [PW-1:0] p);
        logic [PW-1:0] mag;
        logic [PW-1:0] r;
        mag = p[PW-1] ? (~p + 1'b1) : p;
        r   = (mag + HALF_PW) >> FRAC_BITS;
        return p[PW-1] ? $signed(~r + 1'b1) : $signed(r);
    endfunction

    // accumulator to int16, rounded and saturated
    function automatic logic signed [SAMPLE_W-1:0] to_sample(input logic [ACC_W-1:0] acc);
        logic [ACC_W-1:0]           mag;
        logic [ACC_W-1:0]           r;
        logic signed [SAMPLE_W-1:0] v;
        mag = acc[ACC_W-1] ? (~acc + 1'b1) : acc;
        r   = (mag + HALF_ACC) >> FRAC_BITS;
        if (!acc[ACC_W-1])
        begin
            v = (r > ACC_W'(32767)) ? 16'sh7FFF : $signed(r[SAMPLE_W-1:0]);
        end
        else
        begin
            v = (r > ACC_W'(32768)) ? 16'sh8000 : $signed(~r[SAMPLE_W-1:0] + 1'b1);
        end
        return v;
    endfunction

endpackage
`default_nettype wire

FILE: rtl/core/cosine_kernel_stereo_resampler_q24.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cosine_kernel_stereo_resampler_q24
// Stereo int16 resampler with a Q24 cosine-convolution kernel; register
// file, output register and the sequenced core.
//
// channel   direction  handshake            payload
// s_*       in         tvalid/tready        tdata: left_in, right_in
// m_*       out        tvalid/tready        tdata: left_out, right_out; tlast: run_end
// cfg_*     in         cfg_we               cfg_index, cfg_data
//
// each kernel weight and each tap use the shared multiplier; a downsample beat
// accumulates three taps; an upsample beat emits up to MAX_OUT_PER_IN output
// frames of four taps each
// rst_n clears state to upsample mode, step 1.0, scale 1.0, phase 2.0
// s_tready is high only while the core is idle; a held output frame stalls
// the core until m_tready takes it
// ----------------------------------------------------------------------------
module cosine_kernel_stereo_resampler_q24
    import ckr_pkg::*;
#(
    parameter int MAX_OUT_PER_IN = MAX_OUT_DEFAULT
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    input  wire logic [31:0]           s_tdata,   // left_in, right_in
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    output logic [31:0]                m_tdata,   // left_out, right_out
    output logic                       m_tlast,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data
);

    logic               mode_reg;
    logic [STEP_W-1:0]  step_reg;
    logic [SCALE_W-1:0] scale_reg;
    logic               out_valid_reg;
    ckr_frame_t         out_frame_reg;
    ckr_cfg_t           cfg;
    logic               out_full;
    logic               out_push;
    ckr_frame_t         core_frame;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= 1'b1;
            step_reg  <= STEP_W'(Q_ONE);
            scale_reg <= SCALE_W'(Q_ONE);
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_MODE:  mode_reg  <= cfg_data[0];
                REG_STEP:  step_reg  <= cfg_data[STEP_W-1:0];
                REG_SCALE: scale_reg <= cfg_data[SCALE_W-1:0];
                default:   mode_reg  <= mode_reg;
            endcase
        end
    end

    always_comb
    begin
        cfg.mode_wr  = cfg_we && (cfg_index == REG_MODE);
        cfg.mode_val = cfg_data[0];
        cfg.mode     = mode_reg;
        cfg.step     = step_reg;
        cfg.scale    = scale_reg;
    end

    assign out_full = out_valid_reg && !m_tready;

    ckr_core #(
        .MAX_OUT_PER_IN (MAX_OUT_PER_IN)
    ) u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_left   (s_tdata[15:0]),
        .in_right  (s_tdata[31:16]),
        .out_full  (out_full),
        .out_push  (out_push),
        .out_frame (core_frame)
    );

    // output beat register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_push)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_push)
        begin
            out_frame_reg <= core_frame;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_frame_reg.right, out_frame_reg.left};
    assign m_tlast  = out_frame_reg.last;

endmodule
`default_nettype wire

FILE: rtl/core/ckr_mul.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ckr_mul
// Shared signed multiplier with a registered product.
// ----------------------------------------------------------------------------
module ckr_mul
    import ckr_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 en,
    input  wire logic signed [MW-1:0] a,
    input  wire logic signed [MW-1:0] b,
    output logic signed [PW-1:0]      p
);

    logic signed [PW-1:0] p_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p_reg <= a * b;
        end
    end

    assign p = p_reg;

endmodule
`default_nettype wire

FILE: rtl/core/ckr_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ckr_core
// Sequencer and state: kernel evaluation, tap accumulation, phase tracking
// and frame emission, with all multiplies on one shared multiplier.
// ----------------------------------------------------------------------------
module ckr_core
    import ckr_pkg::*;
#(
    parameter int MAX_OUT_PER_IN = MAX_OUT_DEFAULT
)
(
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire ckr_cfg_t                   cfg,
    input  wire logic                       in_valid,
    output logic                            in_ready,
    input  wire logic signed [SAMPLE_W-1:0] in_left,
    input  wire logic signed [SAMPLE_W-1:0] in_right,
    input  wire logic                       out_full,
    output logic                            out_push,
    output ckr_frame_t                      out_frame
);

    localparam int NW = $clog2(MAX_OUT_PER_IN + 1);

    localparam logic signed [XW-1:0]      X_ONE   = XW'(Q_ONE);
    localparam logic signed [XW-1:0]      X_HALF  = XW'(Q_HALF);
    localparam logic [PHASE_W-1:0]        PH_ONE  = PHASE_W'(Q_ONE);
    localparam logic [PHASE_W-1:0]        PH_TWO  = PHASE_W'(Q_TWO);
    localparam logic signed [MW-1:0]      M_ONE   = MW'(Q_ONE);
    localparam logic signed [MW-1:0]      M_TWO   = MW'(Q_TWO);
    localparam logic signed [MW-1:0]      M_THREE = MW'(Q_THREE);
    localparam logic signed [PW-1:0]      P_HALF  = PW'(Q_HALF);
    localparam logic [WIDE_W-1:0]         W_LIMIT = WIDE_W'(PROD_LIMIT);
    localparam logic [WIDE_W-1:0]         W_HALF  = WIDE_W'(Q_HALF);

    ckr_state_t state_reg;
    ckr_state_t state_next;

    logic [PHASE_W-1:0]        phase_reg;
    logic [ACC_W-1:0]          hist_l_reg [4];
    logic [ACC_W-1:0]          hist_r_reg [4];
    logic [NW-1:0]             n_reg;
    logic [1:0]                tap_reg;
    logic                      side_reg;

    logic signed [SAMPLE_W-1:0] sl_reg;
    logic signed [SAMPLE_W-1:0] sr_reg;
    logic signed [XW-1:0]       xt_reg;
    logic [XW-1:0]              ax_reg;
    logic                       neg_reg;
    logic [WIDE_W-1:0]          wide_reg;
    logic signed [MW-1:0]       u_reg;
    logic signed [MW-1:0]       u2_reg;
    logic signed [MW-1:0]       om_reg;
    logic signed [MW-1:0]       i0_reg;
    logic signed [MW-1:0]       k_reg;
    logic [ACC_W-1:0]           accl_reg;
    logic [ACC_W-1:0]           accr_reg;

    logic                      mul_en;
    logic signed [MW-1:0]      mul_a;
    logic signed [MW-1:0]      mul_b;
    logic signed [PW-1:0]      prod;
    logic signed [PW-1:0]      prod_rnd;

    logic signed [XW-1:0]      xs;
    logic [WIDE_W-1:0]         wide_sum;
    logic [WIDE_W-1:0]         wide_rnd;
    logic signed [MW-1:0]      umag;
    logic signed [MW-1:0]      t1;
    logic [MW-1:0]             t1mag;
    logic [MW-1:0]             tq;
    logic signed [MW-1:0]      tval;
    logic signed [MW-1:0]      i_val;
    logic [ACC_W-1:0]          tap_prod;
    logic signed [SAMPLE_W-1:0] left_op;
    logic signed [SAMPLE_W-1:0] right_op;
    logic signed [XW-1:0]      phase_x;
    logic                      up_more;
    logic                      ds_emit;
    logic                      last_tap;

    ckr_mul u_mul (
        .clk (clk),
        .en  (mul_en),
        .a   (mul_a),
        .b   (mul_b),
        .p   (prod)
    );

    // shared datapath helpers
    always_comb
    begin
        prod_rnd = round_prod(prod);
        xs       = side_reg ? (xt_reg - X_HALF) : (xt_reg + X_HALF);
        wide_sum = wide_reg + {{(WIDE_W-PW){1'b0}}, prod};
        wide_rnd = (wide_sum + W_HALF) >> FRAC_BITS;
        umag     = (wide_sum > W_LIMIT) ? M_TWO : $signed(wide_rnd[MW-1:0]);
        t1       = prod_rnd[MW-1:0];
        t1mag    = t1[MW-1] ? (~t1 + 1'b1) : t1;
        tq       = (t1mag + MW'(2)) >> 2;
        tval     = t1[MW-1] ? $signed(~tq + 1'b1) : $signed(tq);
        if (prod_rnd > P_HALF)
        begin
            i_val = MW'(Q_HALF);
        end
        else if (prod_rnd < -P_HALF)
        begin
            i_val = -MW'(Q_HALF);
        end
        else
        begin
            i_val = prod_rnd[MW-1:0];
        end
        tap_prod = {{(ACC_W-PW){prod[PW-1]}}, prod};
        left_op  = cfg.mode ? $signed(hist_l_reg[tap_reg][SAMPLE_W-1:0]) : sl_reg;
        right_op = cfg.mode ? $signed(hist_r_reg[tap_reg][SAMPLE_W-1:0]) : sr_reg;
        phase_x  = {{(XW-PHASE_W){phase_reg[PHASE_W-1]}}, phase_reg};
        up_more  = (n_reg < NW'(MAX_OUT_PER_IN)) && ($signed(phase_reg) < $signed(PH_ONE));
        ds_emit  = $signed({phase_reg[PHASE_W-1], phase_reg})
                   > $signed({12'd0, cfg.step} + 41'(Q_HALF));
        last_tap = cfg.mode ? (tap_reg == 2'd3) : (tap_reg == 2'd2);
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:     if (in_valid) state_next = cfg.mode ? ST_UP_CHECK : ST_ARG;
            ST_ARG:      state_next = ST_MHI;
            ST_MHI:      state_next = ST_MLO;
            ST_MLO:      state_next = ST_USAT;
            ST_USAT:     state_next = ST_U2;
            ST_U2:       state_next = ST_U2W;
            ST_U2W:      state_next = ST_T1;
            ST_T1:       state_next = ST_T1W;
            ST_T1W:      state_next = ST_UT;
            ST_UT:       state_next = ST_IW;
            ST_IW:       state_next = side_reg ? ST_TL : ST_ARG;
            ST_TL:       state_next = ST_TR;
            ST_TR:       state_next = ST_TRW;
            ST_TRW:
            begin
                if (last_tap)
                begin
                    state_next = cfg.mode ? ST_UP_ADV : ST_DS_PH;
                end
                else
                begin
                    state_next = ST_ARG;
                end
            end
            ST_DS_PH:    state_next = ST_DS_CHK;
            ST_DS_CHK:   state_next = ds_emit ? ST_DS_EMIT : ST_IDLE;
            ST_DS_EMIT:  if (!out_full) state_next = ST_IDLE;
            ST_UP_CHECK: state_next = up_more ? ST_ARG : ST_IDLE;
            ST_UP_ADV:   state_next = ST_UP_EMIT;
            ST_UP_EMIT:  if (!out_full) state_next = up_more ? ST_ARG : ST_IDLE;
            default:     state_next = ST_IDLE;
        endcase
    end

    // outputs and multiplier operands
    always_comb
    begin
        in_ready  = 1'b0;
        out_push  = 1'b0;
        out_frame = '0;
        mul_en    = 1'b0;
        mul_a     = '0;
        mul_b     = '0;
        unique case (state_reg)
            ST_IDLE:    in_ready = 1'b1;
            ST_MHI:
            begin
                mul_en = 1'b1;
                mul_a  = {{(MW-HI_W){1'b0}}, ax_reg[XW-1:LO_W]};
                mul_b  = {{(MW-SCALE_W){1'b0}}, cfg.scale};
            end
            ST_MLO:
            begin
                mul_en = 1'b1;
                mul_a  = {{(MW-LO_W){1'b0}}, ax_reg[LO_W-1:0]};
                mul_b  = {{(MW-SCALE_W){1'b0}}, cfg.scale};
            end
            ST_U2:
            begin
                mul_en = 1'b1;
                mul_a  = u_reg;
                mul_b  = u_reg;
            end
            ST_T1:
            begin
                mul_en = 1'b1;
                mul_a  = u2_reg;
                mul_b  = M_THREE - u2_reg;
            end
            ST_UT:
            begin
                mul_en = 1'b1;
                mul_a  = u_reg;
                mul_b  = om_reg;
            end
            ST_TL:
            begin
                mul_en = 1'b1;
                mul_a  = {{(MW-SAMPLE_W){left_op[SAMPLE_W-1]}}, left_op};
                mul_b  = k_reg;
            end
            ST_TR:
            begin
                mul_en = 1'b1;
                mul_a  = {{(MW-SAMPLE_W){right_op[SAMPLE_W-1]}}, right_op};
                mul_b  = k_reg;
            end
            ST_DS_EMIT:
            begin
                out_push        = !out_full;
                out_frame.left  = to_sample(hist_l_reg[0]);
                out_frame.right = to_sample(hist_r_reg[0]);
                out_frame.last  = 1'b1;
            end
            ST_UP_EMIT:
            begin
                out_push        = !out_full;
                out_frame.left  = to_sample(accl_reg);
                out_frame.right = to_sample(accr_reg);
                out_frame.last  = !up_more;
            end
            default:    in_ready = 1'b0;
        endcase
    end

    // control state, phase and history
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            phase_reg <= PH_TWO;
            n_reg     <= '0;
            tap_reg   <= '0;
            side_reg  <= 1'b0;
            for (int i = 0; i < 4; i++)
            begin
                hist_l_reg[i] <= '0;
                hist_r_reg[i] <= '0;
            end
        end
        else if (cfg.mode_wr)
        begin
            state_reg <= ST_IDLE;
            phase_reg <= cfg.mode_val ? PH_TWO : '0;
            for (int i = 0; i < 4; i++)
            begin
                hist_l_reg[i] <= '0;
                hist_r_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            case (state_reg)
                ST_IDLE:
                begin
                    if (in_valid)
                    begin
                        tap_reg  <= '0;
                        side_reg <= 1'b0;
                        n_reg    <= '0;
                        if (cfg.mode)
                        begin
                            for (int i = 0; i < 3; i++)
                            begin
                                hist_l_reg[i] <= hist_l_reg[i+1];
                                hist_r_reg[i] <= hist_r_reg[i+1];
                            end
                            hist_l_reg[3] <= {{(ACC_W-SAMPLE_W){in_left[SAMPLE_W-1]}}, in_left};
                            hist_r_reg[3] <= {{(ACC_W-SAMPLE_W){in_right[SAMPLE_W-1]}},
                                              in_right};
                        end
                    end
                end
                ST_IW:      side_reg <= ~side_reg;
                ST_TR:      if (!cfg.mode) hist_l_reg[tap_reg] <= hist_l_reg[tap_reg] + tap_prod;
                ST_TRW:
                begin
                    if (!cfg.mode)
                    begin
                        hist_r_reg[tap_reg] <= hist_r_reg[tap_reg] + tap_prod;
                    end
                    tap_reg <= tap_reg + 2'd1;
                end
                ST_DS_PH:   phase_reg <= phase_reg + PH_ONE;
                ST_DS_EMIT:
                begin
                    if (!out_full)
                    begin
                        hist_l_reg[0] <= hist_l_reg[1];
                        hist_l_reg[1] <= hist_l_reg[2];
                        hist_l_reg[2] <= '0;
                        hist_r_reg[0] <= hist_r_reg[1];
                        hist_r_reg[1] <= hist_r_reg[2];
                        hist_r_reg[2] <= '0;
                        phase_reg     <= phase_reg - {{(PHASE_W-STEP_W){1'b0}}, cfg.step};
                    end
                end
                ST_UP_CHECK:
                begin
                    if (up_more)
                    begin
                        tap_reg <= '0;
                    end
                    else
                    begin
                        phase_reg <= phase_reg - PH_ONE;
                    end
                end
                ST_UP_ADV:
                begin
                    phase_reg <= phase_reg + {{(PHASE_W-STEP_W){1'b0}}, cfg.step};
                    n_reg     <= n_reg + 1'b1;
                end
                ST_UP_EMIT:
                begin
                    if (!out_full)
                    begin
                        if (up_more)
                        begin
                            tap_reg <= '0;
                        end
                        else
                        begin
                            phase_reg <= phase_reg - PH_ONE;
                        end
                    end
                end
                default:    tap_reg <= tap_reg;
            endcase
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    sl_reg <= in_left;
                    sr_reg <= in_right;
                    xt_reg <= phase_x;
                end
            end
            ST_ARG:
            begin
                ax_reg  <= xs[XW-1] ? (~xs + 1'b1) : xs;
                neg_reg <= xs[XW-1];
            end
            ST_MLO:     wide_reg <= {{(WIDE_W-PW){1'b0}}, prod} << LO_W;
            ST_USAT:    u_reg <= neg_reg ? -umag : umag;
            ST_U2W:     u2_reg <= prod_rnd[MW-1:0];
            ST_T1W:     om_reg <= M_ONE - tval;
            ST_IW:
            begin
                if (side_reg)
                begin
                    k_reg <= i0_reg - i_val;
                end
                else
                begin
                    i0_reg <= i_val;
                end
            end
            ST_TR:      if (cfg.mode) accl_reg <= accl_reg + tap_prod;
            ST_TRW:
            begin
                if (cfg.mode)
                begin
                    accr_reg <= accr_reg + tap_prod;
                    xt_reg   <= xt_reg - X_ONE;
                end
                else
                begin
                    xt_reg <= xt_reg - {{(XW-STEP_W){1'b0}}, cfg.step};
                end
            end
            ST_UP_CHECK:
            begin
                xt_reg   <= phase_x + X_ONE;
                accl_reg <= '0;
                accr_reg <= '0;
            end
            ST_UP_EMIT:
            begin
                // keep the held frame until the output register takes it
                if (!out_full)
                begin
                    xt_reg   <= phase_x + X_ONE;
                    accl_reg <= '0;
                    accr_reg <= '0;
                end
            end
            default:    neg_reg <= neg_reg;
        endcase
    end

endmodule
`default_nettype wire

FILE: sim/cosine_kernel_stereo_resampler_q24_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cosine_kernel_stereo_resampler_q24_tb
// Drives stereo frames through the resampler in both modes, over a range of
// step and kernel-scale settings, with random idling on both streams and one
// long output hold-off. A bit-exact predictor of the cosine-kernel
// arithmetic builds the expected output frames, and every output beat is
// compared against them in order.
// ----------------------------------------------------------------------------
module cosine_kernel_stereo_resampler_q24_tb;
    import ckr_pkg::*;

    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
    localparam int WD_LIMIT = 20000;
    localparam int SETTLE = 400;

    class resampler_sb;
        bit               upsample;
        longint           step;
        longint           scale;
        bit [63:0]        acc_l[4];
        bit [63:0]        acc_r[4];
        bit [PHASE_W-1:0] ph;
        ckr_frame_t       pending[$];
        int               errors;

        function new();
            upsample = 1;
            step = Q_ONE;
            scale = Q_ONE;
            errors = 0;
            clear_state();
        endfunction

        function void clear_state();
            for (int i = 0; i < 4; i++)
            begin
                acc_l[i] = '0;
                acc_r[i] = '0;
            end
            ph = upsample ? PHASE_W'(Q_TWO) : '0;
        endfunction

        function longint ph_val();
            return longint'($signed(ph));
        endfunction

        function longint rshift(longint p);
            bit        neg;
            bit [63:0] mag;
            bit [63:0] r;
            neg = p < 0;
            mag = neg ? -p : p;
            r = (mag + 64'(Q_HALF)) >> FRAC_BITS;
            return neg ? -$signed(r) : $signed(r);
        endfunction

        function longint qmul(longint a, longint b);
            return rshift(a * b);
        endfunction

        function longint half_integral(longint x, longint b);
            bit [63:0] ax;
            longint    u;
            longint    u2;
            longint    t;
            ax = x < 0 ? -x : x;
            if (b == 0)
                u = 0;
            else if (ax > 64'(PROD_LIMIT) / 64'(b))
                u = x < 0 ? -Q_TWO : Q_TWO;
            else
                u = qmul(x, b);
            if (u > Q_TWO)
                u = Q_TWO;
            else if (u < -Q_TWO)
                u = -Q_TWO;
            u2 = qmul(u, u);
            t = qmul(u2, Q_THREE - u2);
            t = qmul(t, Q_ONE >>> 2);
            u = qmul(u, Q_ONE - t);
            if (u > Q_HALF)
                u = Q_HALF;
            else if (u < -Q_HALF)
                u = -Q_HALF;
            return u;
        endfunction

        function longint weight(longint x);
            return half_integral(x + Q_HALF, scale) - half_integral(x - Q_HALF, scale);
        endfunction

        function logic [15:0] to_pcm(bit [63:0] acc);
            longint v;
            v = rshift($signed(acc));
            if (v > 32767)
                v = 32767;
            else if (v < -32768)
                v = -32768;
            return v[15:0];
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
            if (idx == REG_MODE)
            begin
                upsample = val[0];
                clear_state();
            end
            else if (idx == REG_STEP)
                step = longint'(val[STEP_W-1:0]);
            else if (idx == REG_SCALE)
                scale = longint'(val[SCALE_W-1:0]);
        endfunction

        function void take_frame(logic signed [15:0] l, logic signed [15:0] r);
            longint     sl;
            longint     sr;
            longint     d;
            longint     k;
            bit [63:0]  al;
            bit [63:0]  ar;
            int         n;
            ckr_frame_t f;
            sl = l;
            sr = r;
            if (!upsample)
            begin
                d = ph_val();
                for (int i = 0; i < 3; i++)
                begin
                    k = weight(d - i * step);
                    acc_l[i] += 64'(sl * k);
                    acc_r[i] += 64'(sr * k);
                end
                ph = PHASE_W'(d + Q_ONE);
                d = ph_val();
                if (d > step + Q_HALF)
                begin
                    f.left = to_pcm(acc_l[0]);
                    f.right = to_pcm(acc_r[0]);
                    f.last = 1'b1;
                    pending.push_back(f);
                    acc_l[0] = acc_l[1];
                    acc_l[1] = acc_l[2];
                    acc_l[2] = '0;
                    acc_r[0] = acc_r[1];
                    acc_r[1] = acc_r[2];
                    acc_r[2] = '0;
                    ph = PHASE_W'(d - step);
                end
                return;
            end
            for (int i = 0; i < 3; i++)
            begin
                acc_l[i] = acc_l[i + 1];
                acc_r[i] = acc_r[i + 1];
            end
            acc_l[3] = 64'(sl);
            acc_r[3] = 64'(sr);
            n = 0;
            while (n < MAX_OUT_DEFAULT && ph_val() < Q_ONE)
            begin
                d = ph_val();
                al = '0;
                ar = '0;
                for (int i = 0; i < 4; i++)
                begin
                    k = weight(d + Q_ONE - i * Q_ONE);
                    al += acc_l[i] * 64'(k);
                    ar += acc_r[i] * 64'(k);
                end
                f.left = to_pcm(al);
                f.right = to_pcm(ar);
                f.last = 1'b0;
                pending.push_back(f);
                n++;
                ph = PHASE_W'(d + step);
            end
            if (n > 0)
                pending[$].last = 1'b1;
            ph = PHASE_W'(ph_val() - Q_ONE);
        endfunction

        function void check_beat(ckr_frame_t got);
            ckr_frame_t exp_f;
            if (pending.size() == 0)
            begin
                $display("%0t: unexpected beat %h", $time, got);
                errors++;
                return;
            end
            exp_f = pending.pop_front();
            if (got.left !== exp_f.left)
            begin
                $display("%0t: left_out expected %0d actual %0d", $time, exp_f.left, got.left);
                errors++;
            end
            if (got.right !== exp_f.right)
            begin
                $display("%0t: right_out expected %0d actual %0d", $time, exp_f.right,
                         got.right);
                errors++;
            end
            if (got.last !== exp_f.last)
            begin
                $display("%0t: run_end expected %0b actual %0b", $time, exp_f.last, got.last);
                errors++;
            end
        endfunction
    endclass

    logic                  clk = 0;
    logic                  rst_n = 0;
    logic                  s_tvalid = 0;
    logic                  s_tready;
    logic [31:0]           s_tdata = '0;   // left_in, right_in
    logic                  m_tvalid;
    logic                  m_tready = 0;
    logic [31:0]           m_tdata;        // left_out, right_out
    logic                  m_tlast;
    logic                  cfg_we = 0;
    logic [CFG_IDX_W-1:0]  cfg_index = REG_MODE;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    resampler_sb sb = new();
    int send_idle = 0;
    int recv_idle = 0;
    int hold_left = 0;
    int quiet = 0;

    cosine_kernel_stereo_resampler_q24 dut (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always #2 clk = ~clk;

    // output side: check and stall
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
                sb.check_beat({m_tlast, m_tdata[31:16], m_tdata[15:0]});
            if (hold_left > 0)
            begin
                hold_left--;
                m_tready <= 1'b0;
            end
            else
                m_tready <= $urandom_range(99) >= recv_idle;
        end
    end

    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we || !rst_n)
            quiet = 0;
        else
            quiet++;
        if (quiet == WD_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    task automatic send_frame(logic [15:0] l, logic [15:0] r);
        while ($urandom_range(99) < send_idle)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {r, l};
        do
            @(posedge clk);
        while (!s_tready);
        sb.take_frame(l, r);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        sb.write_reg(idx, val);
        @(posedge clk);
    endtask

    function automatic logic [15:0] pick_sample();
        case ($urandom_range(7))
            0: return 16'h8000;
            1: return 16'h7FFF;
            2: return 16'h0000;
            3: return 16'hFFFF;
            default: return 16'($urandom);
        endcase
    endfunction

    initial
    begin
        logic        mode_t[10];
        int          step_t[10];
        int          scale_t[10];
        int          count_t[10];
        logic [15:0] corner[4];
        mode_t  = '{0, 0, 0, 1, 1, 1, 0, 1, 0, 1};
        step_t  = '{33554432, 268435456, 1048576, 1048576, 1000000, 12582912,
                    0, 0, 25165824, 16777216};
        scale_t = '{8388608, 1048576, 67108864, 16777216, 0, 12582912,
                    0, 0, 11184811, 1};
        count_t = '{40, 40, 30, 15, 8, 40, 40, 40, 30, 15};
        corner  = '{16'h8000, 16'h7FFF, 16'h0000, 16'hFFFF};

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings, extremes on both channels
        for (int i = 0; i < 4; i++)
            for (int j = 0; j < 4; j++)
                if (j == i || j == 3 - i)
                    send_frame(corner[i], corner[j]);
        drain();

        for (int p = 0; p < 10; p++)
        begin
            send_idle = (p % 4 == 1 || p % 4 == 3) ? ((p % 4 == 1) ? 47 : 23) : 0;
            recv_idle = (p % 4 == 2 || p % 4 == 3) ? ((p % 4 == 2) ? 47 : 23) : 0;
            if (p == 6)
            begin
                step_t[p] = $urandom_range(16777216, 67108864);
                scale_t[p] = $urandom_range(1, 33554432);
            end
            if (p == 7)
            begin
                step_t[p] = $urandom_range(8388608, 33554432);
                scale_t[p] = $urandom_range(1, 67108864);
            end
            write_reg(REG_STEP, CFG_DATA_W'(step_t[p]));
            write_reg(REG_SCALE, CFG_DATA_W'(scale_t[p]));
            if (p == 8)
                write_reg(REG_UNUSED, '1);
            write_reg(REG_MODE, CFG_DATA_W'(mode_t[p]));
            if (p == 5)
                hold_left = 300;
            for (int n = 0; n < count_t[p]; n++)
                send_frame(pick_sample(), pick_sample());
            drain();
        end

        if (sb.errors == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

FILE: cosine_kernel_stereo_resampler_q24.f
rtl/core/ckr_pkg.sv
rtl/core/ckr_mul.sv
rtl/core/ckr_core.sv
rtl/core/cosine_kernel_stereo_resampler_q24.sv
sim/cosine_kernel_stereo_resampler_q24_tb.sv
